>>> rtl/core/dsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and codes of the dual serial controller register block.
// ----------------------------------------------------------------------------
package dsc_pkg;

   // Request kinds carried in req_tuser
   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_LINE  = 2'd2;

   // Register indexes
   localparam logic [3:0] REG_CMD     = 4'd0;
   localparam logic [3:0] REG_IE      = 4'd1;
   localparam logic [3:0] REG_VECTOR  = 4'd2;
   localparam logic [3:0] REG_SYNC    = 4'd3;
   localparam logic [3:0] REG_DATA    = 4'd8;
   localparam logic [3:0] REG_MASTER  = 4'd9;
   localparam logic [3:0] REG_EXTMASK = 4'd15;

   // Command field of register 0 (bits 5..3)
   localparam logic [2:0] CMD_POINT_HIGH = 3'd1;
   localparam logic [2:0] CMD_RESET_EXT  = 3'd2;

   // Fixed status bits: clear-to-send and the constant high bits
   localparam logic [7:0] STATUS_BASE = 8'h64;
   localparam logic [7:0] READ_ONE    = 8'h07;
   localparam logic [2:0] CODE_B      = 3'd1;
   localparam logic [2:0] CODE_A      = 3'd5;

   typedef struct packed {
      logic [1:0] req_type;
      logic [2:0] address;
      logic [7:0] data;
      logic       channel;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
   } result_type;

   function automatic logic [7:0] status_byte(input logic cd, input logic hunt);
      status_byte = STATUS_BASE | {3'b000, hunt, cd, 3'b000};
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/dsc_input_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_input_reg
// Input register: captures one request transfer and holds it until used.
// ----------------------------------------------------------------------------
module dsc_input_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire dsc_pkg::item_type in_item,
   input  wire logic              step,
   output logic                   held_valid,
   output dsc_pkg::item_type      held_item
);

   logic              valid_ff, valid_in;
   dsc_pkg::item_type item_ff;

   assign in_ready   = !valid_ff || step;
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/dsc_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_regs
// Register file, status change detection and interrupt logic. One request
// is applied per step; the result is produced in the same cycle.
// ----------------------------------------------------------------------------
module dsc_regs (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire dsc_pkg::item_type item,
   output dsc_pkg::result_type    result,
   output logic                   irq_level
);

   logic [3:0] ptr_ff, ptr_in;
   logic [7:0] vec_ff, vec_in;
   logic       mc_ff, mc_in;            // master control bit 4 (status high)
   logic [1:0] pend_ff, pend_in;        // bit 1 channel A, bit 0 channel B
   logic       irq_ff, irq_in;
   logic [1:0] cd_ff, cd_in;
   logic [1:0] hunt_ff, hunt_in;
   logic [1:0] prev_cd_ff, prev_cd_in;
   logic [1:0] prev_hunt_ff, prev_hunt_in;
   logic [1:0] lat_valid_ff, lat_valid_in;
   logic [1:0] lat_cd_ff, lat_cd_in;
   logic [1:0] lat_hunt_ff, lat_hunt_in;
   logic [1:0] ie_ff, ie_in;            // enable bit 0 of register 1
   logic [7:0] mask_ff [2];
   logic [7:0] mask_in [2];

   logic       ch;
   logic [3:0] sel;
   logic [7:0] rd;
   logic       check;
   logic       trig;
   logic [2:0] code;

   assign irq_level = irq_ff;

   always_comb begin
      ptr_in       = ptr_ff;
      vec_in       = vec_ff;
      mc_in        = mc_ff;
      pend_in      = pend_ff;
      irq_in       = irq_ff;
      cd_in        = cd_ff;
      hunt_in      = hunt_ff;
      prev_cd_in   = prev_cd_ff;
      prev_hunt_in = prev_hunt_ff;
      lat_valid_in = lat_valid_ff;
      lat_cd_in    = lat_cd_ff;
      lat_hunt_in  = lat_hunt_ff;
      ie_in        = ie_ff;
      mask_in      = mask_ff;
      rd           = 8'h00;
      check        = 1'b0;
      trig         = 1'b0;
      code         = dsc_pkg::CODE_B;

      ch  = (item.req_type == dsc_pkg::REQ_LINE) ? item.channel : item.address[1];
      sel = item.address[2] ? dsc_pkg::REG_DATA : ptr_ff;

      unique case (item.req_type)
         dsc_pkg::REQ_READ: begin
            check = 1'b1;
            if (!item.address[2]) begin
               ptr_in = 4'd0;
            end
            unique case (sel)
               dsc_pkg::REG_CMD: begin
                  if (lat_valid_ff[ch]) begin
                     rd               = dsc_pkg::status_byte(lat_cd_ff[ch], lat_hunt_ff[ch]);
                     lat_valid_in[ch] = 1'b0;
                  end else begin
                     rd = dsc_pkg::status_byte(cd_ff[ch], hunt_ff[ch]);
                  end
               end
               dsc_pkg::REG_IE: rd = dsc_pkg::READ_ONE;
               dsc_pkg::REG_VECTOR: begin
                  rd = vec_ff;
                  if (!ch && (pend_ff != 2'b00)) begin
                     // report channel B first, then A, and drop what was reported
                     if (pend_ff[0]) begin
                        code       = dsc_pkg::CODE_B;
                        pend_in[0] = 1'b0;
                     end else begin
                        code       = dsc_pkg::CODE_A;
                        pend_in[1] = 1'b0;
                     end
                     if (mc_ff) begin
                        rd = {vec_ff[7], code, vec_ff[3:0]};
                     end else begin
                        rd = {vec_ff[7:4], code, vec_ff[0]};
                     end
                  end
               end
               dsc_pkg::REG_SYNC: begin
                  if (ch) begin
                     rd = {4'b0000, pend_ff[1], 2'b00, pend_ff[0]};
                  end
               end
               dsc_pkg::REG_EXTMASK: rd = mask_ff[ch];
               default: rd = 8'h00;
            endcase
         end
         dsc_pkg::REQ_WRITE: begin
            check = 1'b1;
            if (!item.address[2]) begin
               ptr_in = 4'd0;
            end
            unique case (sel)
               dsc_pkg::REG_CMD: begin
                  ptr_in = {item.data[5:3] == dsc_pkg::CMD_POINT_HIGH, item.data[2:0]};
                  if (item.data[5:3] == dsc_pkg::CMD_RESET_EXT) begin
                     lat_valid_in[ch] = 1'b0;
                     pend_in[ch]      = 1'b0;
                  end
               end
               dsc_pkg::REG_IE:      ie_in[ch]   = item.data[0];
               dsc_pkg::REG_VECTOR:  vec_in      = item.data;
               dsc_pkg::REG_SYNC:    hunt_in[ch] = item.data[4];
               dsc_pkg::REG_MASTER: begin
                  mc_in = item.data[4];
                  if (item.data[7:6] == 2'b11) begin
                     // hardware reset command: restore everything
                     ptr_in       = 4'd0;
                     vec_in       = 8'h00;
                     mc_in        = 1'b0;
                     pend_in      = 2'b00;
                     cd_in        = 2'b11;
                     hunt_in      = 2'b00;
                     prev_cd_in   = 2'b11;
                     prev_hunt_in = 2'b00;
                     lat_valid_in = 2'b00;
                     ie_in        = 2'b00;
                     mask_in[0]   = 8'h00;
                     mask_in[1]   = 8'h00;
                  end
               end
               dsc_pkg::REG_EXTMASK: mask_in[ch] = item.data;
               default: ;
            endcase
         end
         dsc_pkg::REQ_LINE: begin
            check     = 1'b1;
            cd_in[ch] = |item.data;
         end
         default: ;
      endcase

      if (check) begin
         // only carrier (bit 3) and hunt (bit 4) can change in the status byte
         trig = ((cd_in[ch] ^ prev_cd_in[ch]) & mask_in[ch][3])
              | ((hunt_in[ch] ^ prev_hunt_in[ch]) & mask_in[ch][4]);
         if (trig) begin
            lat_valid_in[ch] = 1'b1;
            lat_cd_in[ch]    = cd_in[ch];
            lat_hunt_in[ch]  = hunt_in[ch];
            pend_in[ch]      = 1'b1;
         end
         prev_cd_in[ch]   = cd_in[ch];
         prev_hunt_in[ch] = hunt_in[ch];
         irq_in           = |(pend_in & ie_in);
      end

      result.read_data = rd;
      result.irq       = irq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= 4'd0;
         vec_ff       <= 8'h00;
         mc_ff        <= 1'b0;
         pend_ff      <= 2'b00;
         irq_ff       <= 1'b0;
         cd_ff        <= 2'b11;
         hunt_ff      <= 2'b00;
         prev_cd_ff   <= 2'b11;
         prev_hunt_ff <= 2'b00;
         lat_valid_ff <= 2'b00;
         ie_ff        <= 2'b00;
         mask_ff[0]   <= 8'h00;
         mask_ff[1]   <= 8'h00;
      end else if (step) begin
         ptr_ff       <= ptr_in;
         vec_ff       <= vec_in;
         mc_ff        <= mc_in;
         pend_ff      <= pend_in;
         irq_ff       <= irq_in;
         cd_ff        <= cd_in;
         hunt_ff      <= hunt_in;
         prev_cd_ff   <= prev_cd_in;
         prev_hunt_ff <= prev_hunt_in;
         lat_valid_ff <= lat_valid_in;
         ie_ff        <= ie_in;
         mask_ff      <= mask_in;
      end
   end

   // latched status value is only read while its valid bit is set
   always_ff @(posedge clock) begin
      if (step) begin
         lat_cd_ff   <= lat_cd_in;
         lat_hunt_ff <= lat_hunt_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/dsc_output_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_output_reg
// Result register: holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module dsc_output_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire dsc_pkg::result_type load_result,
   output logic                     has_space,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output dsc_pkg::result_type      out_result
);

   logic                valid_ff, valid_in;
   dsc_pkg::result_type result_ff;

   assign has_space  = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/dual_serial_controller_status_regs_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_serial_controller_status_regs_core
// Two-channel serial controller register interface with external status
// interrupts.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one bus read, bus write or carrier line update per transfer.
//     req_tuser carries the request kind; req_tdata carries address, data
//     and line channel.
//   rsp channel: exactly one result per request, in order: the read byte
//     (zero for writes and line updates) and the interrupt level after it.
//   Path: a request taken into the input register is applied when the result
//   register has space, and its result is registered in the result register
//   at that edge; from there it transfers on the rsp channel.
//   Throughput is one request per cycle while rsp_tready is high, set by the
//   single register-update step between the input and result registers.
//   Stall: while rsp_tready is low the result holds, one more request waits
//   in the input register, and then req_tready drops.
//   Reset: synchronous and active high; both channel registers empty, all
//   controller registers at their reset values, carrier detect high.
// ----------------------------------------------------------------------------
module dual_serial_controller_status_regs_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // address[2:0], data[10:3], channel[11], zero
   input  wire logic [1:0]  req_tuser,  // req_type[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata   // read_data[7:0], irq[8], zero
);

   dsc_pkg::item_type   req_item;
   dsc_pkg::item_type   held_item;
   dsc_pkg::result_type step_result;
   dsc_pkg::result_type out_result;
   logic                held_valid;
   logic                has_space;
   logic                step;
   logic                irq_level;

   assign req_item.req_type = req_tuser;
   assign req_item.address  = req_tdata[2:0];
   assign req_item.data     = req_tdata[10:3];
   assign req_item.channel  = req_tdata[11];

   // advance the held request when the result register can take its result
   assign step = held_valid && has_space;

   dsc_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .step       (step),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   dsc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (held_item),
      .result    (step_result),
      .irq_level (irq_level)
   );

   dsc_output_reg u_output_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (step),
      .load_result (step_result),
      .has_space   (has_space),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (out_result)
   );

   assign rsp_tdata = {7'b0000000, out_result.irq, out_result.read_data};

`ifndef SYNTHESIS
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(step))
      else $error("result appeared without a processed request");

   a_irq_matches_level: assert property (@(posedge clock) disable iff (reset)
      step |=> (rsp_tdata[8] == irq_level))
      else $error("reported irq differs from interrupt level register");

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> held_valid)
      else $error("accepted request was not held");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !step)
      else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire
